// File: rtl/hsv_pkg.sv
// hsv_pkg: shared types, constants and helper functions for the hsv to rgb pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

   // field types
   typedef logic [8:0]  hue_type;
   typedef logic [6:0]  pct_type;
   typedef logic [5:0]  rem_type;
   typedef logic [12:0] factor_type;
   typedef logic [19:0] num_type;
   typedef logic [7:0]  chan_type;
   typedef logic [26:0] quot_in_type;

   // color wheel sectors, 60 degrees each
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   // range limits
   localparam hue_type    HUE_MAX     = 9'd360;
   localparam pct_type    PCT_MAX     = 7'd100;
   localparam rem_type    SECTOR_SPAN = 6'd60;
   localparam factor_type FULL_NUM    = 13'd6000;
   localparam num_type    NUM_MAX     = 20'd600000;

   // scale: floor(num * 255999 / 600000000) = floor(floor(num * 85333 / 2^9) / 390625)
   localparam logic [16:0] SCALE_MUL   = 17'd85333;
   localparam int          SCALE_SHIFT = 9;
   localparam logic [18:0] SCALE_DIV   = 19'd390625;
   // reciprocal of the divisor, floor(2^36 / 390625)
   localparam logic [17:0] RECIP_MUL   = 18'd175921;
   localparam int          RECIP_SHIFT = 36;

   // per-sector stage outputs
   typedef struct packed {
      sector_type sector;
      pct_type    val;
      factor_type fp;
      factor_type fq;
      factor_type ft;
   } factor_bundle_type;

   // routed channel numerators
   typedef struct packed {
      num_type r;
      num_type g;
      num_type b;
   } rgb_num_type;

   // first hue of a sector
   function automatic hue_type sector_base(input sector_type sec);
      hue_type base;
      begin
         base = 9'(sec) * 9'(SECTOR_SPAN);
         return base;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/hsv_sector.sv
// hsv_sector: input saturation, sector split and the three saturation factors
// depends on hsv_pkg; two register stages
`timescale 1ns / 1ps
`default_nettype none

module hsv_sector import hsv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire hue_type           hue,
   input  wire pct_type           sat,
   input  wire pct_type           val,
   output      logic              out_valid,
   output      factor_bundle_type out_bundle
);

   hue_type    hue_sat;
   pct_type    sat_in, val_in;
   sector_type sector_in;
   hue_type    rem_full;
   rem_type    rem_in;

   logic       valid_a_ff;
   pct_type    sat_ff, val_a_ff;
   sector_type sector_a_ff;
   rem_type    rem_ff;

   factor_type s_rem, s_comp;
   factor_bundle_type bundle_in;

   logic              valid_b_ff;
   factor_bundle_type bundle_ff;

   // clamp inputs and find the sector
   always_comb begin
      hue_sat = (hue > HUE_MAX) ? HUE_MAX : hue;
      sat_in  = (sat > PCT_MAX) ? PCT_MAX : sat;
      val_in  = (val > PCT_MAX) ? PCT_MAX : val;
      priority if (hue_sat >= sector_base(SEC_MAG_RED)) begin
         sector_in = SEC_MAG_RED;
      end else if (hue_sat >= sector_base(SEC_BLU_MAG)) begin
         sector_in = SEC_BLU_MAG;
      end else if (hue_sat >= sector_base(SEC_CYN_BLU)) begin
         sector_in = SEC_CYN_BLU;
      end else if (hue_sat >= sector_base(SEC_GRN_CYN)) begin
         sector_in = SEC_GRN_CYN;
      end else if (hue_sat >= sector_base(SEC_YEL_GRN)) begin
         sector_in = SEC_YEL_GRN;
      end else begin
         sector_in = SEC_RED_YEL;
      end
      rem_full = hue_sat - sector_base(sector_in);
      rem_in   = rem_full[5:0];
   end

   // stage a
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (adv) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sat_ff      <= sat_in;
         val_a_ff    <= val_in;
         sector_a_ff <= sector_in;
         rem_ff      <= rem_in;
      end
   end

   // saturation factors for p, q and t
   always_comb begin
      s_rem  = 13'(sat_ff) * 13'(rem_ff);
      s_comp = 13'(sat_ff) * 13'(SECTOR_SPAN - rem_ff);
      bundle_in.sector = sector_a_ff;
      bundle_in.val    = val_a_ff;
      bundle_in.fp     = 13'(PCT_MAX - sat_ff) * 13'(SECTOR_SPAN);
      bundle_in.fq     = FULL_NUM - s_rem;
      bundle_in.ft     = FULL_NUM - s_comp;
   end

   // stage b
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (adv) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bundle_ff <= bundle_in;
      end
   end

   assign out_valid  = valid_b_ff;
   assign out_bundle = bundle_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_mix.sv
// hsv_mix: value products and routing of v, p, q, t to red, green and blue
// depends on hsv_pkg; one register stage
`timescale 1ns / 1ps
`default_nettype none

module hsv_mix import hsv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire factor_bundle_type in_bundle,
   output      logic              out_valid,
   output      rgb_num_type       out_num
);

   num_type     nv, np, nq, nt;
   rgb_num_type num_in;
   logic        valid_ff;
   rgb_num_type num_ff;

   // products with value, then route by sector
   always_comb begin
      nv = 20'(in_bundle.val) * 20'(FULL_NUM);
      np = 20'(in_bundle.val) * 20'(in_bundle.fp);
      nq = 20'(in_bundle.val) * 20'(in_bundle.fq);
      nt = 20'(in_bundle.val) * 20'(in_bundle.ft);
      unique case (in_bundle.sector)
         SEC_RED_YEL: begin
            num_in = '{r: nv, g: nt, b: np};
         end
         SEC_YEL_GRN: begin
            num_in = '{r: nq, g: nv, b: np};
         end
         SEC_GRN_CYN: begin
            num_in = '{r: np, g: nv, b: nt};
         end
         SEC_CYN_BLU: begin
            num_in = '{r: np, g: nq, b: nv};
         end
         SEC_BLU_MAG: begin
            num_in = '{r: nt, g: np, b: nv};
         end
         default: begin
            num_in = '{r: nv, g: np, b: nq};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_scale.sv
// hsv_scale: scales one channel numerator to 8 bits by 255999 / 600000000
// depends on hsv_pkg; three register stages, reciprocal multiply with one correction
`timescale 1ns / 1ps
`default_nettype none

module hsv_scale import hsv_pkg::*; (
   input  wire logic     clock,
   input  wire logic     adv,
   input  wire num_type  num,
   output      chan_type chan
);

   logic [35:0] scaled;
   quot_in_type x_in;
   quot_in_type x_ff;

   logic [44:0] est;
   chan_type    q0_in;
   chan_type    q0_ff;
   quot_in_type x2_ff;

   quot_in_type back;
   quot_in_type rem;
   chan_type    chan_in;
   chan_type    chan_ff;

   // stage d: numerator times 85333, drop the power-of-two part of the divisor
   always_comb begin
      scaled = 36'(num) * 36'(SCALE_MUL);
      x_in   = scaled[SCALE_SHIFT +: $bits(quot_in_type)];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
      end
   end

   // stage e: quotient estimate, low by at most one
   always_comb begin
      est   = 45'(x_ff) * 45'(RECIP_MUL);
      q0_in = est[RECIP_SHIFT +: $bits(chan_type)];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q0_ff <= q0_in;
         x2_ff <= x_ff;
      end
   end

   // stage f: remainder check and correction
   always_comb begin
      back    = 27'(q0_ff) * 27'(SCALE_DIV);
      rem     = x2_ff - back;
      chan_in = (rem >= 27'(SCALE_DIV)) ? q0_ff + 8'd1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb_convert_top.sv
// hsv_to_rgb_convert_top: pixel pipeline from hsv (degrees, percent) to 8-bit rgb
// depends on hsv_pkg, hsv_sector, hsv_mix, hsv_scale
//
//   channel | ports                                         | direction
//   req     | req_valid, req_stall, req_hue_degrees,        | in (stall out)
//           | req_saturation_pct, req_value_pct             |
//   rsp     | rsp_valid, rsp_stall, rsp_red_out,            | out (stall in)
//           | rsp_green_out, rsp_blue_out                   |
//
// one pixel per clock unless a held result stalls the pipeline
// stages: clamp and sector, saturation factors, value products and routing,
// then three stages of the constant divide in each channel
// synchronous reset clears the valid bits only; payload registers are not reset
// a stalled result freezes the whole pipeline, req_stall follows within the cycle
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_convert_top import hsv_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_stall,
   input  wire hue_type  req_hue_degrees,
   input  wire pct_type  req_saturation_pct,
   input  wire pct_type  req_value_pct,
   output      logic     rsp_valid,
   input  wire logic     rsp_stall,
   output      chan_type rsp_red_out,
   output      chan_type rsp_green_out,
   output      chan_type rsp_blue_out
);

   logic              adv;
   logic              valid_b;
   factor_bundle_type bundle_b;
   logic              valid_c;
   rgb_num_type       num_c;
   logic              valid_d_ff, valid_e_ff, valid_f_ff;

   // global advance: only a held result stops the pipe
   assign adv       = !(valid_f_ff && rsp_stall);
   assign req_stall = !adv;

   hsv_sector u_sector (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_valid),
      .hue        (req_hue_degrees),
      .sat        (req_saturation_pct),
      .val        (req_value_pct),
      .out_valid  (valid_b),
      .out_bundle (bundle_b)
   );

   hsv_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (valid_b),
      .in_bundle (bundle_b),
      .out_valid (valid_c),
      .out_num   (num_c)
   );

   // valid bits for the divide stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
         valid_f_ff <= 1'b0;
      end else if (adv) begin
         valid_d_ff <= valid_c;
         valid_e_ff <= valid_d_ff;
         valid_f_ff <= valid_e_ff;
      end
   end

   hsv_scale u_scale_red (
      .clock (clock),
      .adv   (adv),
      .num   (num_c.r),
      .chan  (rsp_red_out)
   );

   hsv_scale u_scale_green (
      .clock (clock),
      .adv   (adv),
      .num   (num_c.g),
      .chan  (rsp_green_out)
   );

   hsv_scale u_scale_blue (
      .clock (clock),
      .adv   (adv),
      .num   (num_c.b),
      .chan  (rsp_blue_out)
   );

   assign rsp_valid = valid_f_ff;

   // a held result must hold off new input
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("result held but input not stalled");

   // no pipeline valid bit moves while stalled
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable({valid_b, valid_c, valid_d_ff, valid_e_ff, valid_f_ff}))
      else $error("pipeline moved during stall");

   // routed numerators stay within full scale
   a_num_range: assert property (@(posedge clock) disable iff (reset)
      valid_c |-> (num_c.r <= NUM_MAX && num_c.g <= NUM_MAX && num_c.b <= NUM_MAX))
      else $error("channel numerator above full scale");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for hsv_to_rgb_convert_top, hsv pixels in and rgb pixels out
// depends on hsv_pkg and the rtl of hsv_to_rgb_convert_top; the integer color model lives here
`timescale 1ns / 1ps

module testbench;
   import hsv_pkg::*;

   // expected rgb pixel
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_pixel_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   hue_type  req_hue_degrees;
   pct_type  req_saturation_pct;
   pct_type  req_value_pct;
   logic     rsp_valid;
   logic     rsp_stall;
   chan_type rsp_red_out;
   chan_type rsp_green_out;
   chan_type rsp_blue_out;

   rgb_pixel_type pending_rgb[$];
   int            mismatch_count = 0;
   int            send_idle_pct  = 0;
   int            rsp_stall_pct  = 0;

   hsv_to_rgb_convert_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_hue_degrees    (req_hue_degrees),
      .req_saturation_pct (req_saturation_pct),
      .req_value_pct      (req_value_pct),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red_out        (rsp_red_out),
      .rsp_green_out      (rsp_green_out),
      .rsp_blue_out       (rsp_blue_out)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

   // exact integer hsv to rgb: channel = floor(num * 255999 / 600000000)
   function automatic rgb_pixel_type hsv_to_rgb_predict(input hue_type hue_in,
                                                        input pct_type sat_in,
                                                        input pct_type val_in);
      logic [63:0]   hue, sat, val, sec_num, rem;
      logic [63:0]   nv, np, nq, nt, nr, ng, nb;
      sector_type    sector;
      rgb_pixel_type pix;
      begin
         hue = (hue_in > HUE_MAX) ? 64'(HUE_MAX) : 64'(hue_in);
         sat = (sat_in > PCT_MAX) ? 64'(PCT_MAX) : 64'(sat_in);
         val = (val_in > PCT_MAX) ? 64'(PCT_MAX) : 64'(val_in);

         // hue 360 folds into the last sector with a full remainder
         sec_num = hue / 64'd60;
         if (sec_num > 64'd5) begin
            sec_num = 64'd5;
         end
         rem    = hue - 64'd60 * sec_num;
         sector = sector_type'(sec_num[2:0]);

         nv = val * 64'd6000;
         np = val * (64'd100 - sat) * 64'd60;
         nq = val * (64'd6000 - sat * rem);
         nt = val * (64'd6000 - sat * (64'd60 - rem));

         // route products by sector
         case (sector)
            SEC_RED_YEL: begin nr = nv; ng = nt; nb = np; end
            SEC_YEL_GRN: begin nr = nq; ng = nv; nb = np; end
            SEC_GRN_CYN: begin nr = np; ng = nv; nb = nt; end
            SEC_CYN_BLU: begin nr = np; ng = nq; nb = nv; end
            SEC_BLU_MAG: begin nr = nt; ng = np; nb = nv; end
            default: begin nr = nv; ng = np; nb = nq; end
         endcase

         pix.red   = chan_type'((nr * 64'd255999) / 64'd600000000);
         pix.green = chan_type'((ng * 64'd255999) / 64'd600000000);
         pix.blue  = chan_type'((nb * 64'd255999) / 64'd600000000);
         return pix;
      end
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // check each result transfer, then record each input transfer
   always @(posedge clock) begin
      rgb_pixel_type exp_pix;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rgb.size() == 0) begin
               $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                        rsp_red_out, rsp_green_out, rsp_blue_out);
               mismatch_count++;
            end else begin
               exp_pix = pending_rgb.pop_front();
               if (rsp_red_out !== exp_pix.red) begin
                  $display("%0t: red mismatch expected %0d actual %0d", $time,
                           exp_pix.red, rsp_red_out);
                  mismatch_count++;
               end
               if (rsp_green_out !== exp_pix.green) begin
                  $display("%0t: green mismatch expected %0d actual %0d", $time,
                           exp_pix.green, rsp_green_out);
                  mismatch_count++;
               end
               if (rsp_blue_out !== exp_pix.blue) begin
                  $display("%0t: blue mismatch expected %0d actual %0d", $time,
                           exp_pix.blue, rsp_blue_out);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_rgb.push_back(hsv_to_rgb_predict(req_hue_degrees, req_saturation_pct,
                                                     req_value_pct));
         end
      end
   end

   // one input transfer, with random idle cycles ahead of it
   task automatic send_pixel(input hue_type hue, input pct_type sat, input pct_type val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_hue_degrees    <= hue;
      req_saturation_pct <= sat;
      req_value_pct      <= val;
      do @(posedge clock); while (req_stall);
   endtask

   // sender goes quiet until every expected pixel is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rgb.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // random pixels, mostly in range, some using the full field width
   task automatic send_random_pixels(input int count);
      hue_type hue;
      pct_type sat, val;
      for (int i = 0; i < count; i++) begin
         hue = ($urandom_range(99) < 85) ? hue_type'($urandom_range(360))
                                         : hue_type'($urandom_range(511));
         sat = ($urandom_range(99) < 85) ? pct_type'($urandom_range(100))
                                         : pct_type'($urandom_range(127));
         val = ($urandom_range(99) < 85) ? pct_type'($urandom_range(100))
                                         : pct_type'($urandom_range(127));
         send_pixel(hue, sat, val);
      end
   endtask

   // sector edges, grey, black, hue 360 and out-of-range inputs
   task automatic test_directed_corners();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_pixel(9'd0,   7'd100, 7'd100);
      send_pixel(9'd60,  7'd100, 7'd100);
      send_pixel(9'd120, 7'd100, 7'd100);
      send_pixel(9'd180, 7'd100, 7'd100);
      send_pixel(9'd240, 7'd100, 7'd100);
      send_pixel(9'd300, 7'd100, 7'd100);
      send_pixel(9'd360, 7'd100, 7'd100);
      send_pixel(9'd359, 7'd100, 7'd100);
      send_pixel(9'd59,  7'd50,  7'd80);
      send_pixel(9'd61,  7'd37,  7'd100);
      send_pixel(9'd119, 7'd100, 7'd1);
      send_pixel(9'd181, 7'd77,  7'd63);
      send_pixel(9'd299, 7'd13,  7'd99);
      send_pixel(9'd0,   7'd0,   7'd0);
      send_pixel(9'd200, 7'd0,   7'd100);
      send_pixel(9'd45,  7'd0,   7'd57);
      send_pixel(9'd361, 7'd100, 7'd100);
      send_pixel(9'd511, 7'd127, 7'd127);
      send_pixel(9'd200, 7'd101, 7'd100);
      send_pixel(9'd90,  7'd127, 7'd50);
      send_pixel(9'd270, 7'd50,  7'd127);
      send_pixel(9'd30,  7'd100, 7'd0);
      send_pixel(9'd330, 7'd1,   7'd1);
      wait_for_results();
   endtask

   task automatic test_random_no_idle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_random_pixels(340);
      wait_for_results();
   endtask

   task automatic test_random_sender_idle();
      send_idle_pct = 79;
      rsp_stall_pct = 0;
      send_random_pixels(330);
      wait_for_results();
   endtask

   task automatic test_random_receiver_stall();
      send_idle_pct = 0;
      rsp_stall_pct = 79;
      send_random_pixels(330);
      wait_for_results();
   endtask

   task automatic test_random_both_idle();
      send_idle_pct = 23;
      rsp_stall_pct = 23;
      send_random_pixels(330);
      wait_for_results();
   endtask

   // reset, run each test, then drain and report
   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_hue_degrees    <= '0;
      req_saturation_pct <= '0;
      req_value_pct      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      // let the pipeline settle past its latency
      rsp_stall_pct = 0;
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && pending_rgb.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/hsv_pkg.sv
rtl/hsv_sector.sv
rtl/hsv_mix.sv
rtl/hsv_scale.sv
rtl/hsv_to_rgb_convert_top.sv
tb/testbench.sv
